>>> hw/rtl/dcth_pkg.sv
`default_nettype none

package dcth_pkg;

	localparam int SIDE = 8;
	localparam int IDX_W = $clog2(SIDE);
	localparam int CELLS = SIDE * SIDE;
	localparam int CELL_W = $clog2(CELLS);
	localparam int MASTER_BITS = 24;
	localparam int COS_FRAC_DEFAULT = 14;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic col;
	} mac_ctl_t;

	// magnitude of round(2^24 * 0.5 * cos(m*pi/16))
	function automatic int master_mag(input logic [3:0] m);
		int v;
		v = 0;
		unique case (m)
			4'd0: v = 8388608;
			4'd1: v = 8227423;
			4'd2: v = 7750063;
			4'd3: v = 6974873;
			4'd4: v = 5931642;
			4'd5: v = 4660461;
			4'd6: v = 3210181;
			4'd7: v = 1636536;
			default: v = 0;
		endcase
		return v;
	endfunction

	// fixed-point a_k * cos((2n+1)k*pi/16), halves rounded away from zero
	function automatic int cos_entry(input logic [IDX_W-1:0] k, input logic [IDX_W-1:0] n,
			input int frac);
		logic [4:0] m;
		logic       neg;
		int         s;
		int         mag;
		m = {1'b0, n, 1'b1} * {2'b00, k};
		neg = 1'b0;
		s = MASTER_BITS - frac;
		if (k == '0) begin
			m = 5'd4;
		end else begin
			if (m > 5'd16) begin
				m = 5'd0 - m;
			end
			if (m > 5'd8) begin
				m = 5'd16 - m;
				neg = 1'b1;
			end
		end
		mag = (master_mag(m[3:0]) + (1 << (s - 1))) >>> s;
		return neg ? -mag : mag;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dcth_mac.sv
`default_nettype none

module dcth_mac
	import dcth_pkg::*;
#(
	parameter int COS_FRACTION_BITS = COS_FRAC_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire mac_ctl_t                              ctl_s1,
	input  wire logic signed [COS_FRACTION_BITS+12:0]  a_s1,
	input  wire logic signed [COS_FRACTION_BITS:0]     c_s1,
	output      mac_ctl_t                              ctl_s2,
	output      logic signed [2*COS_FRACTION_BITS+16:0] acc_next
);

	localparam int RW = COS_FRACTION_BITS + 13;
	localparam int CW = COS_FRACTION_BITS + 1;
	localparam int PW = RW + CW;
	localparam int AW = 2 * COS_FRACTION_BITS + 17;

	logic signed [PW-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= a_s1 * c_s1;
		end
		if (ctl_s2.valid) begin
			acc_q <= acc_next;
		end
	end

	assign acc_next = (ctl_s2.first ? AW'(0) : acc_q) + AW'(prod_s2);

endmodule

`default_nettype wire

>>> hw/rtl/dct_perceptual_hash_8x8.sv
// 64-bit perceptual hash of an 8x8 grayscale image.
// input channel: in_valid/in_ready carry one pixel per transfer, row-major,
// with last_pixel marking the final pixel of the image. pixels are taken one
// per cycle while the block is idle.
// output channel: out_valid/out_ready carry one hash per image.
// after the last pixel transfer the block runs the row pass and the column
// pass on one shared multiply-accumulate unit fed from the pixel and row
// memories, then the mean compare of each stored coefficient against the sum,
// with a pipeline drain after each pass.
// in_ready is low during that work.
// the finished hash sits in an output register; while the receiver stalls,
// pixels of the next image are taken, and the next transform waits before
// handing over its hash until the previous one has been transferred.
// reset clears the state, the counters, the coefficient sum, the hash
// registers and the valid flags; the memories are not cleared.
`default_nettype none

module dct_perceptual_hash_8x8
	import dcth_pkg::*;
#(
	parameter int COS_FRACTION_BITS = COS_FRAC_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  pixel,
	input  wire logic        last_pixel,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [63:0] hash
);

	localparam int RW = COS_FRACTION_BITS + 13;
	localparam int CW = COS_FRACTION_BITS + 1;
	localparam int AW = 2 * COS_FRACTION_BITS + 17;
	localparam int SW = 2 * COS_FRACTION_BITS + 24;
	localparam int CNT_W = 3 * IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_ROW_DRAIN,
		ST_COL,
		ST_COL_DRAIN,
		ST_CMP,
		ST_CMP_DRAIN,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CELL_W-1:0]     pix_cnt_q;
	logic signed [SW-1:0]  sum_q;
	logic [CELLS-1:0]      hash_q;
	logic [63:0]           out_hash_q;
	logic                  out_valid_q;

	logic [7:0]            pixel_mem [CELLS];
	logic signed [RW-1:0]  row_mem [CELLS];
	logic signed [AW-1:0]  coef_mem [CELLS];

	logic [7:0]            pix_rd_q;
	logic signed [RW-1:0]  row_rd_q;
	logic signed [AW-1:0]  coef_rd_q;

	logic                  in_xfer;
	logic                  issue_row;
	logic                  issue_col;
	logic                  issue_cmp;
	logic [IDX_W-1:0]      cos_k;
	logic [IDX_W-1:0]      cos_n;
	logic [CELL_W-1:0]     pix_raddr;
	logic [CELL_W-1:0]     row_raddr;
	logic [CELL_W-1:0]     coef_raddr;
	logic signed [CW-1:0]  cos_s0;
	mac_ctl_t              ctl_s0;

	mac_ctl_t              ctl_s1;
	logic signed [CW-1:0]  cos_s1;
	logic [CELL_W-1:0]     waddr_s1;
	logic [CELL_W-1:0]     waddr_s2;
	logic                  cmp_v_s1;
	logic [CELL_W-1:0]     cmp_idx_s1;

	logic signed [RW-1:0]  a_s1;
	mac_ctl_t              ctl_s2;
	logic signed [AW-1:0]  acc_next;
	logic                  pipe_busy;
	logic                  coef_gt;
	logic                  out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign issue_row = (state_q == ST_ROW);
	assign issue_col = (state_q == ST_COL);
	assign issue_cmp = (state_q == ST_CMP);
	assign out_valid = out_valid_q;
	assign hash = out_hash_q;
	assign out_free = !out_valid_q || out_ready;

	// row pass: r, v, n; column pass: u, v, r
	assign cos_k = issue_row ? cnt_q[2*IDX_W-1:IDX_W] : cnt_q[CNT_W-1:2*IDX_W];
	assign cos_n = cnt_q[IDX_W-1:0];
	assign pix_raddr = {cnt_q[CNT_W-1:2*IDX_W], cnt_q[IDX_W-1:0]};
	assign row_raddr = {cnt_q[IDX_W-1:0], cnt_q[2*IDX_W-1:IDX_W]};
	assign coef_raddr = cnt_q[CELL_W-1:0];
	assign cos_s0 = CW'(cos_entry(cos_k, cos_n, COS_FRACTION_BITS));

	always_comb begin
		ctl_s0.valid = issue_row || issue_col;
		ctl_s0.first = (cnt_q[IDX_W-1:0] == '0);
		ctl_s0.last = (cnt_q[IDX_W-1:0] == '1);
		ctl_s0.col = issue_col;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pixel_mem[pix_cnt_q] <= pixel;
		end
		pix_rd_q <= pixel_mem[pix_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.last && !ctl_s2.col) begin
			row_mem[waddr_s2] <= RW'(acc_next);
		end
		row_rd_q <= row_mem[row_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.last && ctl_s2.col) begin
			coef_mem[waddr_s2] <= acc_next;
		end
		coef_rd_q <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			ctl_s1 <= ctl_s0;
			cmp_v_s1 <= issue_cmp;
		end
	end

	always_ff @(posedge clk) begin
		cos_s1 <= cos_s0;
		waddr_s1 <= cnt_q[CNT_W-1:IDX_W];
		waddr_s2 <= waddr_s1;
		cmp_idx_s1 <= coef_raddr;
	end

	assign a_s1 = ctl_s1.col ? row_rd_q : RW'($signed({1'b0, pix_rd_q}));

	dcth_mac #(
		.COS_FRACTION_BITS(COS_FRACTION_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.a_s1     (a_s1),
		.c_s1     (cos_s1),
		.ctl_s2   (ctl_s2),
		.acc_next (acc_next)
	);

	assign pipe_busy = ctl_s1.valid || ctl_s2.valid;
	assign coef_gt = ($signed(SW'(coef_rd_q)) <<< 6) > sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pix_cnt_q <= '0;
			sum_q <= '0;
			hash_q <= '0;
			out_hash_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_hash_q <= hash_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl_s2.valid && ctl_s2.last && ctl_s2.col) begin
				sum_q <= sum_q + SW'(acc_next);
			end
			if (cmp_v_s1) begin
				hash_q[cmp_idx_s1] <= coef_gt;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (last_pixel) begin
							pix_cnt_q <= '0;
							cnt_q <= '0;
							state_q <= ST_ROW;
						end else begin
							pix_cnt_q <= pix_cnt_q + 1'b1;
						end
					end
				end
				ST_ROW: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= ST_ROW_DRAIN;
					end
				end
				ST_ROW_DRAIN: begin
					if (!pipe_busy) begin
						cnt_q <= '0;
						sum_q <= '0;
						state_q <= ST_COL;
					end
				end
				ST_COL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= ST_COL_DRAIN;
					end
				end
				ST_COL_DRAIN: begin
					if (!pipe_busy) begin
						cnt_q <= '0;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[CELL_W-1:0] == '1) begin
						state_q <= ST_CMP_DRAIN;
					end
				end
				ST_CMP_DRAIN: begin
					if (!cmp_v_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last_pixel |=> pix_cnt_q == '0)
		else $error("pixel position not cleared after last pixel");

	a_col_starts_empty: assert property (@(posedge clk) disable iff (!arst_n)
		issue_col && $past(state_q) == ST_ROW_DRAIN |-> !pipe_busy)
		else $error("column pass started with row pass still in flight");

	a_no_mac_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		issue_cmp || cmp_v_s1 |-> !ctl_s2.valid)
		else $error("accumulator active during compare");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("hash presented without finished transform");

endmodule

`default_nettype wire

>>> verif/dct_perceptual_hash_8x8_test.sv
`timescale 1ns / 1ps

module dct_perceptual_hash_8x8_test;

	localparam int COS_FRAC = 14;
	localparam int Q24_SHIFT = 24 - COS_FRAC;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 4000;
	localparam int TAIL_CYCLES = 1200;
	localparam int PHASE_ITEMS = 240;
	localparam int PHASE_IMAGES = 4;

	localparam longint MAG_Q24 [9] = '{8388608, 8227423, 7750063, 6974873, 5931642,
		4660461, 3210181, 1636536, 0};

	typedef enum int {
		STYLE_NOISE,
		STYLE_FLAT,
		STYLE_RAMP,
		STYLE_BINARY,
		STYLE_BLOB,
		STYLE_CHECKER
	} image_style_e;

	typedef struct packed {
		logic [7:0] pix;
		logic       last;
	} pixel_xfer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  pixel = 8'd0;
	logic        last_pixel = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] hash;

	pixel_xfer_t pixel_q[$];
	logic [63:0] hash_expect_q[$];
	logic [7:0]  image_mem [64];
	int          write_pos = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pressure_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	int pixels_sent = 0;
	int images_queued = 0;
	int short_images = 0;
	int long_images = 0;
	int hashes_checked = 0;
	int mismatches = 0;
	logic [63:0] hash_want;
	pixel_xfer_t next_xfer;

	dct_perceptual_hash_8x8 #(
		.COS_FRACTION_BITS(COS_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash(hash)
	);

	always #5 clk = ~clk;

	// fixed-point basis value a_k * cos((2n+1)k*pi/16)
	function automatic longint basis_q(input int k, input int n);
		int     m;
		bit     neg;
		longint mag;
		neg = 1'b0;
		m = ((2 * n + 1) * k) % 32;
		if (k == 0) begin
			m = 4;
		end else begin
			if (m > 16) m = 32 - m;
			if (m > 8) begin
				m = 16 - m;
				neg = 1'b1;
			end
		end
		mag = (MAG_Q24[m] + (longint'(1) << (Q24_SHIFT - 1))) >>> Q24_SHIFT;
		return neg ? -mag : mag;
	endfunction

	function automatic logic [63:0] predict_phash();
		longint      ctab [8][8];
		longint      rows [64];
		longint      coef [64];
		longint      total;
		longint      acc;
		logic [63:0] bits;
		bits = '0;
		total = 0;
		for (int k = 0; k < 8; k++)
			for (int n = 0; n < 8; n++)
				ctab[k][n] = basis_q(k, n);
		for (int r = 0; r < 8; r++)
			for (int v = 0; v < 8; v++) begin
				acc = 0;
				for (int n = 0; n < 8; n++)
					acc += longint'(image_mem[r * 8 + n]) * ctab[v][n];
				rows[r * 8 + v] = acc;
			end
		for (int u = 0; u < 8; u++)
			for (int v = 0; v < 8; v++) begin
				acc = 0;
				for (int r = 0; r < 8; r++)
					acc += ctab[u][r] * rows[r * 8 + v];
				coef[u * 8 + v] = acc;
				total += acc;
			end
		for (int i = 0; i < 64; i++)
			if (coef[i] * 64 > total) bits[i] = 1'b1;
		return bits;
	endfunction

	function automatic logic [7:0] style_pixel(input image_style_e style, input int idx,
			input int a, input int b);
		int val;
		case (style)
			STYLE_FLAT: val = a;
			STYLE_RAMP: val = (a * (idx / 8) + b * (idx % 8)) & 255;
			STYLE_BINARY: val = $urandom_range(1) ? 255 : 0;
			STYLE_BLOB: begin
				val = a + $urandom_range(16) - 8;
				if (val < 0) val = 0;
				if (val > 255) val = 255;
			end
			STYLE_CHECKER: val = (((idx / 8) + (idx % 8)) & 1) ? 255 : 0;
			default: val = $urandom_range(255);
		endcase
		return 8'(val);
	endfunction

	function automatic void queue_image(input int len, input image_style_e style,
			input int a, input int b);
		pixel_xfer_t x;
		for (int i = 0; i < len; i++) begin
			x.pix = style_pixel(style, i % 64, a, b);
			x.last = (i == len - 1);
			pixel_q.push_back(x);
		end
		images_queued++;
	endfunction

	function automatic int queue_random_image();
		int           roll;
		int           len;
		image_style_e style;
		roll = $urandom_range(99);
		if (roll < 60) begin
			len = 64;
		end else if (roll < 85) begin
			len = $urandom_range(1, 63);
			short_images++;
		end else begin
			len = $urandom_range(65, 140);
			long_images++;
		end
		style = image_style_e'($urandom_range(4));
		queue_image(len, style, $urandom_range(255), $urandom_range(31));
		return len;
	endfunction

	task automatic drain();
		while (pixel_q.size() != 0 || in_valid || hash_expect_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		int phase_items;
		int phase_images;
		phase_items = 0;
		phase_images = 0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (phase_items < PHASE_ITEMS || phase_images < PHASE_IMAGES) begin
			phase_items += queue_random_image();
			phase_images++;
		end
		drain();
	endtask

	// pixel driver; records every input transfer and predicts the hash at each last pixel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= 8'd0;
			last_pixel <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pixels_sent++;
				image_mem[write_pos] = pixel;
				if (last_pixel) begin
					hash_expect_q.push_back(predict_phash());
					write_pos = 0;
				end else begin
					write_pos = (write_pos + 1) % 64;
				end
			end
			if (!in_valid || in_ready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_xfer = pixel_q.pop_front();
					in_valid <= 1'b1;
					pixel <= next_xfer.pix;
					last_pixel <= next_xfer.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// hash monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (hash_expect_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected hash %016h at %0t", hash, $realtime);
					mismatches++;
				end else begin
					hash_want = hash_expect_q.pop_front();
					hashes_checked++;
					if (hash !== hash_want) begin
						if (mismatches < 10)
							$display("hash mismatch: expected %016h actual %016h at %0t",
								hash_want, hash, $realtime);
						mismatches++;
					end
				end
			end
			if (pressure_armed && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("no transfer for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first image fills every position, then edge images
		queue_image(64, STYLE_FLAT, 255, 0);
		queue_image(1, STYLE_FLAT, 0, 0);
		queue_image(5, STYLE_BINARY, 0, 0);
		queue_image(64, STYLE_FLAT, 0, 0);
		queue_image(64, STYLE_CHECKER, 0, 0);
		short_images += 2;
		drain();

		run_phase(0, 0);
		run_phase(75, 0);
		run_phase(0, 75);
		run_phase(12, 12);

		// long output hold while pixels keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_armed = 1'b1;
		for (int i = 0; i < 4; i++)
			queue_image(64, STYLE_NOISE, 0, 0);
		drain();

		run_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d pixels in %0d images (%0d short, %0d overlong), %0d hashes checked",
			pixels_sent, images_queued, short_images, long_images, hashes_checked);
		$display("idle mixes on both sides plus a %0d-cycle output hold, %0d mismatches",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0 && hash_expect_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
